>>> hw/rtl/pib_pkg.sv
// Shared types, register codes and saturation helpers for the particle integrator.
package pib_pkg;

  localparam int unsigned Q_SHIFT    = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STAGES     = 12;
  localparam int unsigned ARITH_STGS = 8;

  // register index codes (byte address / 4)
  localparam logic [2:0] REG_TIME_STEP       = 3'd0;
  localparam logic [2:0] REG_TIME_SCALE_GAIN = 3'd1;
  localparam logic [2:0] REG_DRAG_GAIN       = 3'd2;
  localparam logic [2:0] REG_GRAVITY_GAIN    = 3'd3;
  localparam logic [2:0] REG_BOUNCE_LOSS     = 3'd4;
  localparam logic [2:0] REG_BORDER_ENABLE   = 3'd5;
  localparam logic [2:0] REG_FRAME_WIDTH     = 3'd6;
  localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd7;

  localparam logic [GAIN_W-1:0]  RST_TIME_STEP       = 24'd0;
  localparam logic [GAIN_W-1:0]  RST_TIME_SCALE_GAIN = 24'd65536;
  localparam logic [GAIN_W-1:0]  RST_DRAG_GAIN       = 24'd65536;
  localparam logic [GAIN_W-1:0]  RST_GRAVITY_GAIN    = 24'd0;
  localparam logic [GAIN_W-1:0]  RST_BOUNCE_LOSS     = 24'd65536;
  localparam logic               RST_BORDER_ENABLE   = 1'b1;
  localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH     = 16'd1024;
  localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT    = 16'd768;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] S40_MAX = 64'sd549755813887;
  localparam logic signed [63:0] S40_MIN = -64'sd549755813888;

  typedef struct packed {
    logic [GAIN_W-1:0]  time_step;
    logic [GAIN_W-1:0]  time_scale_gain;
    logic [GAIN_W-1:0]  drag_gain;
    logic [GAIN_W-1:0]  gravity_gain;
    logic [GAIN_W-1:0]  bounce_loss;
    logic               border_enable;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
    logic signed [39:0] r;
    if (x > S40_MAX) begin
      r = 40'sh7F_FFFF_FFFF;
    end else if (x < S40_MIN) begin
      r = 40'sh80_0000_0000;
    end else begin
      r = x[39:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pib_regs.sv
// APB configuration register file for the particle integrator.
module pib_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pib_pkg::ADDR_W-1:0]  paddr,
  input  logic [pib_pkg::DATA_W-1:0]  pwdata,
  output logic [pib_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output pib_pkg::cfg_t               cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step       <= pib_pkg::RST_TIME_STEP;
      cfg.time_scale_gain <= pib_pkg::RST_TIME_SCALE_GAIN;
      cfg.drag_gain       <= pib_pkg::RST_DRAG_GAIN;
      cfg.gravity_gain    <= pib_pkg::RST_GRAVITY_GAIN;
      cfg.bounce_loss     <= pib_pkg::RST_BOUNCE_LOSS;
      cfg.border_enable   <= pib_pkg::RST_BORDER_ENABLE;
      cfg.frame_width     <= pib_pkg::RST_FRAME_WIDTH;
      cfg.frame_height    <= pib_pkg::RST_FRAME_HEIGHT;
    end else if (wr) begin
      case (idx)
        pib_pkg::REG_TIME_STEP:       cfg.time_step       <= pwdata[23:0];
        pib_pkg::REG_TIME_SCALE_GAIN: cfg.time_scale_gain <= pwdata[23:0];
        pib_pkg::REG_DRAG_GAIN:       cfg.drag_gain       <= pwdata[23:0];
        pib_pkg::REG_GRAVITY_GAIN:    cfg.gravity_gain    <= pwdata[23:0];
        pib_pkg::REG_BOUNCE_LOSS:     cfg.bounce_loss     <= pwdata[23:0];
        pib_pkg::REG_BORDER_ENABLE:   cfg.border_enable   <= pwdata[0];
        pib_pkg::REG_FRAME_WIDTH:     cfg.frame_width     <= pwdata[15:0];
        pib_pkg::REG_FRAME_HEIGHT:    cfg.frame_height    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pib_pkg::REG_TIME_STEP:       prdata = {8'd0, cfg.time_step};
      pib_pkg::REG_TIME_SCALE_GAIN: prdata = {8'd0, cfg.time_scale_gain};
      pib_pkg::REG_DRAG_GAIN:       prdata = {8'd0, cfg.drag_gain};
      pib_pkg::REG_GRAVITY_GAIN:    prdata = {8'd0, cfg.gravity_gain};
      pib_pkg::REG_BOUNCE_LOSS:     prdata = {8'd0, cfg.bounce_loss};
      pib_pkg::REG_BORDER_ENABLE:   prdata = {31'd0, cfg.border_enable};
      pib_pkg::REG_FRAME_WIDTH:     prdata = {16'd0, cfg.frame_width};
      pib_pkg::REG_FRAME_HEIGHT:    prdata = {16'd0, cfg.frame_height};
      default:                      prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/pib_bounce.sv
// Four-stage border clamp and velocity reflection for one axis.
module pib_bounce (
  input  logic                               clk,
  input  logic [3:0]                         en,
  input  logic                               border_enable,
  input  logic [pib_pkg::GAIN_W-1:0]         bounce_loss,
  input  logic signed [31:0]                 pos_in,
  input  logic signed [31:0]                 vel_in,
  input  logic [30:0]                        rad_in,
  input  logic signed [33:0]                 far_in,
  output logic signed [31:0]                 pos_out,
  output logic signed [31:0]                 vel_out,
  output logic [1:0]                         hit_out
);

  // stage 9: near-border compare, reflect product
  logic signed [31:0] pos9, vel9;
  logic signed [33:0] far9;
  logic signed [57:0] prod9;
  logic               lhit9;
  // stage 10: apply near reflection
  logic signed [31:0] pos10, vel10;
  logic signed [33:0] far10;
  logic               lhit10;
  // stage 11: far-border compare, reflect product
  logic signed [31:0] pos11, vel11;
  logic signed [57:0] prod11;
  logic               lhit11, rhit11;
  // stage 12: apply far reflection
  logic signed [31:0] pos12, vel12;
  logic [1:0]         hit12;

  logic signed [31:0] rad_s;
  logic signed [32:0] nv_in, nv10;
  logic signed [24:0] loss_s;
  logic               lhit, rhit;

  always_comb begin
    rad_s  = $signed({1'b0, rad_in});
    loss_s = $signed({1'b0, bounce_loss});
    nv_in  = -$signed({vel_in[31], vel_in});
    nv10   = -$signed({vel10[31], vel10});
    lhit   = border_enable && (pos_in < rad_s);
    rhit   = border_enable && ($signed({{2{pos10[31]}}, pos10}) > far10);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos9  <= lhit ? rad_s : pos_in;
      vel9  <= vel_in;
      far9  <= far_in;
      prod9 <= 58'(nv_in) * 58'(loss_s);
      lhit9 <= lhit;
    end
    if (en[1]) begin
      pos10  <= pos9;
      vel10  <= lhit9 ? pib_pkg::sat32({{22{prod9[57]}}, prod9[57:16]}) : vel9;
      far10  <= far9;
      lhit10 <= lhit9;
    end
    if (en[2]) begin
      pos11  <= rhit ? pib_pkg::sat32({{30{far10[33]}}, far10}) : pos10;
      vel11  <= vel10;
      prod11 <= 58'(nv10) * 58'(loss_s);
      lhit11 <= lhit10;
      rhit11 <= rhit;
    end
    if (en[3]) begin
      pos12 <= pos11;
      vel12 <= rhit11 ? pib_pkg::sat32({{22{prod11[57]}}, prod11[57:16]}) : vel11;
      hit12 <= {rhit11, lhit11};
    end
  end

  assign pos_out = pos12;
  assign vel_out = vel12;
  assign hit_out = hit12;

endmodule

>>> hw/rtl/particle_integrate_border_bounce.sv
// Throughput: one particle per cycle while the output is not stalled; each stage holds one
// multiply (gravity, three displacement gains, two reflections) or the saturate/add after it.
// Stalls collapse bubbles: a stage loads whenever it is empty or the next one moves.
// Reset clears all stage valid bits and loads the register defaults; data regs are not reset.
// Top level: APB registers, stage control and the Euler integration pipeline.
module particle_integrate_border_bounce (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pib_pkg::ADDR_W-1:0]  paddr,
  input  logic [pib_pkg::DATA_W-1:0]  pwdata,
  output logic [pib_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // particle in
  input  logic                        valid,
  output logic                        stall,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          vel_x,
  input  logic signed [31:0]          vel_y,
  input  logic [30:0]                 particle_radius,
  input  logic [30:0]                 particle_mass,
  input  logic                        batch_last,
  // particle out
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [31:0]          new_pos_x,
  output logic signed [31:0]          new_pos_y,
  output logic signed [31:0]          new_vel_x,
  output logic signed [31:0]          new_vel_y,
  output logic [1:0]                  hit_x,
  output logic [1:0]                  hit_y,
  output logic                        batch_last_out
);

  localparam int unsigned N = pib_pkg::STAGES;
  localparam int unsigned M = pib_pkg::ARITH_STGS;

  pib_pkg::cfg_t cfg;

  logic [N:1] vld;
  logic [N:1] en;

  // payload per stage, index 0 = x, 1 = y
  logic signed [31:0] pos_s [1:M][2];
  logic signed [31:0] vel_s [1:M][2];
  logic [30:0]        rad_s [1:M];
  logic               last_s [1:N];
  logic [54:0]        gprod1;
  logic signed [56:0] p1_3 [2];
  logic signed [64:0] p2_4 [2];
  logic signed [39:0] d2_5 [2];
  logic signed [64:0] p3_6 [2];
  logic signed [39:0] d3_7 [2];
  logic signed [33:0] far8 [2];

  logic signed [63:0] gdiff;
  logic signed [24:0] ts_s, tsg_s, dg_s;

  pib_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage enables: load when empty or when the stage ahead moves
  always_comb begin
    en[N] = !vld[N] || !result_stall;
    for (int k = N - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= valid;
      end
      for (int k = 2; k <= N; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    ts_s  = $signed({1'b0, cfg.time_step});
    tsg_s = $signed({1'b0, cfg.time_scale_gain});
    dg_s  = $signed({1'b0, cfg.drag_gain});
    gdiff = $signed({{32{vel_s[1][1][31]}}, vel_s[1][1]})
          - $signed({25'd0, gprod1[54:16]});
  end

  always_ff @(posedge clk) begin
    // stage 1: capture, gravity product
    if (en[1]) begin
      pos_s[1][0] <= pos_x;
      pos_s[1][1] <= pos_y;
      vel_s[1][0] <= vel_x;
      vel_s[1][1] <= vel_y;
      rad_s[1]    <= particle_radius;
      last_s[1]   <= batch_last;
      gprod1      <= 55'(cfg.gravity_gain) * 55'(particle_mass);
    end
    // stage 2 rewrites the velocities and stage M the positions
    for (int k = 2; k <= M; k++) begin
      if (en[k]) begin
        rad_s[k] <= rad_s[k-1];
        if (k != 2) begin
          vel_s[k] <= vel_s[k-1];
        end
        if (k != M) begin
          pos_s[k] <= pos_s[k-1];
        end
      end
    end
    for (int k = 2; k <= N; k++) begin
      if (en[k]) begin
        last_s[k] <= last_s[k-1];
      end
    end
    // stage 2: subtract gravity from vertical velocity
    if (en[2]) begin
      vel_s[2][0] <= vel_s[1][0];
      vel_s[2][1] <= pib_pkg::sat32(gdiff);
    end
    for (int a = 0; a < 2; a++) begin
      if (en[3]) begin
        p1_3[a] <= 57'(vel_s[2][a]) * 57'(ts_s);
      end
      if (en[4]) begin
        p2_4[a] <= 65'($signed(p1_3[a][55:16])) * 65'(tsg_s);
      end
      if (en[5]) begin
        d2_5[a] <= pib_pkg::sat40({{15{p2_4[a][64]}}, p2_4[a][64:16]});
      end
      if (en[6]) begin
        p3_6[a] <= 65'(d2_5[a]) * 65'(dg_s);
      end
      if (en[7]) begin
        d3_7[a] <= pib_pkg::sat40({{15{p3_6[a][64]}}, p3_6[a][64:16]});
      end
      // stage 8: new position, far border value
      if (en[8]) begin
        pos_s[8][a] <= pib_pkg::sat32($signed({{32{pos_s[7][a][31]}}, pos_s[7][a]})
                                    + $signed({{24{d3_7[a][39]}}, d3_7[a]}));
        far8[a] <= $signed({2'b00, (a == 0) ? cfg.frame_width : cfg.frame_height, 16'd0})
                 - $signed({3'b000, rad_s[7]});
      end
    end
  end

  pib_bounce u_bounce_x (
    .clk           (clk),
    .en            (en[12:9]),
    .border_enable (cfg.border_enable),
    .bounce_loss   (cfg.bounce_loss),
    .pos_in        (pos_s[M][0]),
    .vel_in        (vel_s[M][0]),
    .rad_in        (rad_s[M]),
    .far_in        (far8[0]),
    .pos_out       (new_pos_x),
    .vel_out       (new_vel_x),
    .hit_out       (hit_x)
  );

  pib_bounce u_bounce_y (
    .clk           (clk),
    .en            (en[12:9]),
    .border_enable (cfg.border_enable),
    .bounce_loss   (cfg.bounce_loss),
    .pos_in        (pos_s[M][1]),
    .vel_in        (vel_s[M][1]),
    .rad_in        (rad_s[M]),
    .far_in        (far8[1]),
    .pos_out       (new_pos_y),
    .vel_out       (new_vel_y),
    .hit_out       (hit_y)
  );

  assign result_valid   = vld[N];
  assign batch_last_out = last_s[N];

  // input backpressure only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    stall |-> result_valid && result_stall)
    else $error("input stalled while pipeline has room");

  a_no_hit_when_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && !cfg.border_enable |-> hit_x == 2'b00 && hit_y == 2'b00)
    else $error("border hit reported with borders off");

  a_left_clamp_nonneg: assert property (@(posedge clk) disable iff (rst)
    result_valid && (hit_x == 2'b01) |-> !new_pos_x[31])
    else $error("left clamp left a negative position");

  a_top_clamp_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && hit_y[1] |->
      $signed({{2{new_pos_y[31]}}, new_pos_y}) <= $signed({2'b00, cfg.frame_height, 16'd0}))
    else $error("top clamp position beyond frame height");

endmodule

>>> sim/particle_integrate_border_bounce_checker.sv
`timescale 1ns / 100ps
// Checker for the particle integrator: follows register writes, predicts each result beat and compares.
module particle_integrate_border_bounce_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [pib_pkg::ADDR_W-1:0]  paddr,
  input  logic [pib_pkg::DATA_W-1:0]  pwdata,
  input  logic                        valid,
  input  logic                        stall,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          vel_x,
  input  logic signed [31:0]          vel_y,
  input  logic [30:0]                 particle_radius,
  input  logic [30:0]                 particle_mass,
  input  logic                        batch_last,
  input  logic                        result_valid,
  input  logic                        result_stall,
  input  logic signed [31:0]          new_pos_x,
  input  logic signed [31:0]          new_pos_y,
  input  logic signed [31:0]          new_vel_x,
  input  logic signed [31:0]          new_vel_y,
  input  logic [1:0]                  hit_x,
  input  logic [1:0]                  hit_y,
  input  logic                        batch_last_out,
  output int                          fails,
  output int                          in_flight,
  output int                          checked,
  output int                          x_hits,
  output int                          y_hits
);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [1:0]         hit_x;
    logic [1:0]         hit_y;
    logic               last;
  } motion_t;

  // one axis while it goes through the wall checks
  typedef struct packed {
    logic signed [63:0] p;
    logic signed [63:0] v;
    logic [1:0]         hit;
  } axis_t;

  motion_t         expected_motion[$];
  pib_pkg::cfg_t   regs;
  int      errs = 0;
  int      n_checked = 0;
  int      n_x_hits = 0;
  int      n_y_hits = 0;

  // exact product with a Q8.16 gain, then floor to Q16.16
  function automatic logic signed [63:0] gain_floor(input logic signed [63:0] a,
                                                    input logic [23:0] g);
    logic signed [87:0] prod;
    prod = 88'(a) * $signed({64'd0, g});
    return 64'(prod >>> pib_pkg::Q_SHIFT);
  endfunction

  function automatic logic signed [63:0] clamp_to(input logic signed [63:0] x,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic signed [63:0] displace(input logic signed [63:0] p,
                                                  input logic signed [63:0] v,
                                                  input pib_pkg::cfg_t c);
    logic signed [63:0] d;
    d = gain_floor(v, c.time_step);
    d = clamp_to(gain_floor(d, c.time_scale_gain), pib_pkg::S40_MIN, pib_pkg::S40_MAX);
    d = clamp_to(gain_floor(d, c.drag_gain), pib_pkg::S40_MIN, pib_pkg::S40_MAX);
    return clamp_to(p + d, pib_pkg::S32_MIN, pib_pkg::S32_MAX);
  endfunction

  function automatic logic signed [63:0] rebound(input logic signed [63:0] v,
                                                 input logic [23:0] loss);
    return clamp_to(gain_floor(-v, loss), pib_pkg::S32_MIN, pib_pkg::S32_MAX);
  endfunction

  // near wall first, then far wall on what the near check left
  function automatic axis_t wall_bounce(input axis_t a, input logic signed [63:0] r,
                                        input logic [15:0] frame, input logic [23:0] loss);
    axis_t o;
    logic signed [63:0] far_edge;
    o = a;
    far_edge = $signed({32'd0, frame, 16'd0}) - r;
    if (o.p < r) begin
      o.p = r;
      o.v = rebound(o.v, loss);
      o.hit[0] = 1'b1;
    end
    if (o.p > far_edge) begin
      o.p = clamp_to(far_edge, pib_pkg::S32_MIN, pib_pkg::S32_MAX);
      o.v = rebound(o.v, loss);
      o.hit[1] = 1'b1;
    end
    return o;
  endfunction

  function automatic motion_t predict_motion(input pib_pkg::cfg_t c,
                                             input logic signed [31:0] px, py, vx, vy,
                                             input logic [30:0] r, m,
                                             input logic last);
    motion_t o;
    axis_t ax, ay;
    logic [63:0] gm;
    logic signed [63:0] vy_w, rr;
    gm = {40'd0, c.gravity_gain} * {33'd0, m};
    vy_w = 64'(vy);
    vy_w = clamp_to(vy_w - $signed(gm >> pib_pkg::Q_SHIFT), pib_pkg::S32_MIN,
                    pib_pkg::S32_MAX);
    ax.p = displace(64'(px), 64'(vx), c);
    ax.v = 64'(vx);
    ax.hit = 2'b00;
    ay.p = displace(64'(py), vy_w, c);
    ay.v = vy_w;
    ay.hit = 2'b00;
    rr = {33'd0, r};
    if (c.border_enable) begin
      ax = wall_bounce(ax, rr, c.frame_width, c.bounce_loss);
      ay = wall_bounce(ay, rr, c.frame_height, c.bounce_loss);
    end
    o.pos_x = ax.p[31:0];
    o.pos_y = ay.p[31:0];
    o.vel_x = ax.v[31:0];
    o.vel_y = ay.v[31:0];
    o.hit_x = ax.hit;
    o.hit_y = ay.hit;
    o.last  = last;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    motion_t want;
    if (rst) begin
      regs.time_step       = pib_pkg::RST_TIME_STEP;
      regs.time_scale_gain = pib_pkg::RST_TIME_SCALE_GAIN;
      regs.drag_gain       = pib_pkg::RST_DRAG_GAIN;
      regs.gravity_gain    = pib_pkg::RST_GRAVITY_GAIN;
      regs.bounce_loss     = pib_pkg::RST_BOUNCE_LOSS;
      regs.border_enable   = pib_pkg::RST_BORDER_ENABLE;
      regs.frame_width     = pib_pkg::RST_FRAME_WIDTH;
      regs.frame_height    = pib_pkg::RST_FRAME_HEIGHT;
      expected_motion.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[pib_pkg::ADDR_W-1:2])
          pib_pkg::REG_TIME_STEP:       regs.time_step       = pwdata[23:0];
          pib_pkg::REG_TIME_SCALE_GAIN: regs.time_scale_gain = pwdata[23:0];
          pib_pkg::REG_DRAG_GAIN:       regs.drag_gain       = pwdata[23:0];
          pib_pkg::REG_GRAVITY_GAIN:    regs.gravity_gain    = pwdata[23:0];
          pib_pkg::REG_BOUNCE_LOSS:     regs.bounce_loss     = pwdata[23:0];
          pib_pkg::REG_BORDER_ENABLE:   regs.border_enable   = pwdata[0];
          pib_pkg::REG_FRAME_WIDTH:     regs.frame_width     = pwdata[15:0];
          pib_pkg::REG_FRAME_HEIGHT:    regs.frame_height    = pwdata[15:0];
          default: ;
        endcase
      end
      // retire before enqueue so a result can never match a particle from the same edge
      if (result_valid && !result_stall) begin
        if (expected_motion.size() == 0) begin
          $display("%0t: result beat with no particle pending, expected none, got pos %h %h",
                   $time, new_pos_x, new_pos_y);
          errs++;
        end else begin
          want = expected_motion.pop_front();
          check_field("new_pos_x", want.pos_x, new_pos_x);
          check_field("new_pos_y", want.pos_y, new_pos_y);
          check_field("new_vel_x", want.vel_x, new_vel_x);
          check_field("new_vel_y", want.vel_y, new_vel_y);
          check_field("hit_x", {30'd0, want.hit_x}, {30'd0, hit_x});
          check_field("hit_y", {30'd0, want.hit_y}, {30'd0, hit_y});
          check_field("batch_last_out", {31'd0, want.last}, {31'd0, batch_last_out});
          n_checked++;
          if (want.hit_x != 2'b00) n_x_hits++;
          if (want.hit_y != 2'b00) n_y_hits++;
        end
      end
      if (valid && !stall) begin
        expected_motion.push_back(predict_motion(regs, pos_x, pos_y, vel_x, vel_y,
                                                 particle_radius, particle_mass, batch_last));
      end
    end
    fails     <= errs;
    in_flight <= expected_motion.size();
    checked   <= n_checked;
    x_hits    <= n_x_hits;
    y_hits    <= n_y_hits;
  end

endmodule

>>> sim/particle_integrate_border_bounce_tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, register writes, particle stimulus and the final verdict.
module particle_integrate_border_bounce_tb;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 138;
  localparam int SETTLE_TICKS = 16;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [pib_pkg::ADDR_W-1:0]   paddr = '0;
  logic [pib_pkg::DATA_W-1:0]   pwdata = '0;
  logic [pib_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         valid = 1'b0;
  logic                         stall;
  logic signed [31:0]           pos_x = '0;
  logic signed [31:0]           pos_y = '0;
  logic signed [31:0]           vel_x = '0;
  logic signed [31:0]           vel_y = '0;
  logic [30:0]                  particle_radius = '0;
  logic [30:0]                  particle_mass = '0;
  logic                         batch_last = 1'b0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic signed [31:0]           new_pos_x;
  logic signed [31:0]           new_pos_y;
  logic signed [31:0]           new_vel_x;
  logic signed [31:0]           new_vel_y;
  logic [1:0]                   hit_x;
  logic [1:0]                   hit_y;
  logic                         batch_last_out;

  int fails, in_flight, checked, x_hits, y_hits;

  int          send_pct = 0;
  int          drain_pct = 0;
  bit          quiet = 1'b0;
  int          rs_left = 0;
  int          settings = 1;
  logic [15:0] cur_fw = pib_pkg::RST_FRAME_WIDTH;
  logic [15:0] cur_fh = pib_pkg::RST_FRAME_HEIGHT;

  particle_integrate_border_bounce DUT (.*);

  particle_integrate_border_bounce_checker checker_i (.*);

  always #6 clk = ~clk;

  // result side back-pressure in bursts of random length
  always @(posedge clk) begin
    if (rst || quiet) begin
      result_stall <= 1'b0;
      rs_left <= 0;
    end else if (rs_left != 0) begin
      result_stall <= 1'b1;
      rs_left <= rs_left - 1;
    end else if ($urandom_range(99) < drain_pct) begin
      result_stall <= 1'b1;
      rs_left <= $urandom_range(12);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // valid stays high after the beat; whoever acts next decides whether to drop it
  task automatic send_particle(input logic signed [31:0] px, py, vx, vy,
                               input logic [31:0] r, m, input logic last);
    int gap;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    valid <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    vel_x <= vx;
    vel_y <= vy;
    particle_radius <= r[30:0];
    particle_mass <= m[30:0];
    batch_last <= last;
    do @(posedge clk); while (stall);
  endtask

  task automatic drain();
    valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_settings(input logic [23:0] ts, tsg, dg, gg, bl, input logic be,
                               input logic [15:0] fw, fh);
    drain();
    reg_write(pib_pkg::REG_TIME_STEP, {8'd0, ts});
    reg_write(pib_pkg::REG_TIME_SCALE_GAIN, {8'd0, tsg});
    reg_write(pib_pkg::REG_DRAG_GAIN, {8'd0, dg});
    reg_write(pib_pkg::REG_GRAVITY_GAIN, {8'd0, gg});
    reg_write(pib_pkg::REG_BOUNCE_LOSS, {8'd0, bl});
    reg_write(pib_pkg::REG_BORDER_ENABLE, {31'd0, be});
    reg_write(pib_pkg::REG_FRAME_WIDTH, {16'd0, fw});
    reg_write(pib_pkg::REG_FRAME_HEIGHT, {16'd0, fh});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_fw = fw;
    cur_fh = fh;
    settings++;
  endtask

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(7))
      0: return 24'h00_0000;
      1: return 24'hFF_FFFF;
      2, 3, 4: return 24'($urandom_range(0, 32'h0002_0000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_frame();
    case ($urandom_range(5))
      0: return 16'd1;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16, 2048));
    endcase
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // somewhere from 48 units outside the low wall to 48 units past the high one
  function automatic logic signed [31:0] near_frame(input logic [15:0] f);
    longint span, val;
    span = (longint'(f) + 96) << 16;
    val = longint'($urandom) % span - (48 << 16);
    if (val > 64'sh7FFF_FFFF) val = 64'sh7FFF_FFFF;
    return val[31:0];
  endfunction

  task automatic send_random();
    logic signed [31:0] px, py, vx, vy;
    logic [31:0] r, m;
    logic [31:0] w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      px = near_frame(cur_fw);
      py = near_frame(cur_fh);
      vx = $urandom_range(0, 1 << 26) - (1 << 25);
      vy = $urandom_range(0, 1 << 26) - (1 << 25);
      r  = $urandom_range(0, 48 << 16);
      m  = $urandom_range(0, 8 << 16);
    end else if (pick < 85) begin
      px = $urandom;
      py = $urandom;
      vx = $urandom;
      vy = $urandom;
      w = $urandom;
      r = {1'b0, w[30:0]};
      w = $urandom;
      m = {1'b0, w[30:0]};
    end else begin
      px = edge_word();
      py = edge_word();
      vx = edge_word();
      vy = edge_word();
      w = edge_word();
      r = {1'b0, w[30:0]};
      w = edge_word();
      m = {1'b0, w[30:0]};
    end
    send_particle(px, py, vx, vy, r, m, 1'($urandom_range(1)));
  endtask

  initial begin
    int pause_at;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no motion, walls at 1024 x 768
    send_particle(0, 0, 0, 0, 0, 0, 1'b0);
    send_particle(-1, 100 << 16, 5 << 16, 0, 0, 0, 1'b0);
    send_particle((1024 << 16) + 1, 100 << 16, 3 << 16, 0, 0, 0, 1'b1);
    send_particle(100 << 16, -(5 << 16), 0, -(2 << 16), 1 << 16, 0, 1'b0);
    send_particle(100 << 16, 800 << 16, 0, 7 << 16, 1 << 16, 0, 1'b0);
    send_particle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_particle(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  0, 0, 1'b0);
    // radius over half the frame: each axis hits both its near and its far wall
    send_particle(300 << 16, 300 << 16, 1 << 16, 1 << 16, 600 << 16, 0, 1'b0);

    drain_pct = 20;
    // 1/60 s step, light drag, earth-like gravity, some energy lost per bounce
    load_settings(24'd1092, 24'd65536, 24'd62259, 24'd642908, 24'd55705, 1'b1,
                  16'd1024, 16'd768);
    send_particle(50 << 16, 1 << 16, 0, -(200 << 16), 1 << 16, 1 << 16, 1'b0);
    send_particle(1023 << 16, 50 << 16, 300 << 16, 0, 1 << 16, 1 << 16, 1'b0);
    send_particle(-(1 << 16), 50 << 16, 32'sh8000_0000, 0, 0, 1 << 16, 1'b1);
    send_particle(50 << 16, 50 << 16, 0, 32'sh8000_0000, 0, 32'h7FFF_FFFF, 1'b0);

    load_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1,
                  16'hFFFF, 16'hFFFF);
    send_particle(-1, -1, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 1'b0);
    send_particle(32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1'b1);

    load_settings(24'd1092, 24'd65536, 24'd65536, 24'd0, 24'd65536, 1'b0,
                  16'd1024, 16'd768);
    send_particle(-(100 << 16), 2000 << 16, -(50 << 16), 40 << 16, 8 << 16, 0, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_settings(24'd1092, 24'd65536, 24'd62259, 24'd642908, 24'd55705, 1'b1,
                         16'd1024, 16'd768);
        1: load_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                         1'b1, 16'hFFFF, 16'hFFFF);
        2: load_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 16'd1, 16'd1);
        3: load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                         1'b0, rand_frame(), rand_frame());
        // zero width puts the right wall at minus the radius, left of the left one
        4: load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                         1'b1, 16'd0, rand_frame());
        default: load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                               rand_gain(), 1'b1, rand_frame(), rand_frame());
      endcase
      if (ph == PHASES - 1) begin
        quiet = 1'b1;
        send_pct = 0;
        drain_pct = 0;
      end else begin
        send_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 50);
        drain_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 50);
      end
      pause_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold the sender off until the pipe has emptied
        if (i == pause_at) drain();
        send_random();
      end
    end

    drain();
    $display("Covered %0d particles over %0d register settings; %0d results clamped at a side",
             checked, settings, x_hits);
    $display("wall and %0d at the floor or ceiling.", y_hits);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
